[rtl/core/mcr_pkg.sv]
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared constants, codes and payload types of the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

  // Coordinate width of the center and radius fields.
  localparam int COORD_BITS    = 12;
  // Width of the walk column, which may run one past the radius.
  localparam int WALK_X_BITS   = COORD_BITS + 1;
  // Width of result coordinates.
  localparam int OUT_BITS      = 13;
  // Width of the screen size registers.
  localparam int SCREEN_BITS   = 14;
  // Width of the stored decision term.
  localparam int DEC_BITS      = 16;
  // Signed working width for coordinate and decision arithmetic.
  localparam int CALC_BITS     = (COORD_BITS + 6 > DEC_BITS + 1) ? COORD_BITS + 6
                                                                 : DEC_BITS + 1;
  // Result slots produced by one step.
  localparam int SLOTS         = 8;
  localparam int SLOT_IDX_BITS = 3;
  // Configuration register index width.
  localparam int CFG_IDX_BITS  = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 1'd1;

  // Reset values of the screen size registers.
  localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = 14'd240;
  localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = 14'd320;

  // Input item modes.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_SPAN  = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_IDLE  = 2'd3
  } kind_t;

  // Input item.
  typedef struct packed {
    logic                  mode;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [COORD_BITS-1:0] radius;
    logic                  fill;
  } in_item_t;

  // Result item.
  typedef struct packed {
    kind_t               kind;
    logic [OUT_BITS-1:0] row;
    logic [OUT_BITS-1:0] col_start;
    logic [OUT_BITS-1:0] col_end;
    logic                last_of_step;
    logic                circle_done;
  } out_item_t;

  // One buffered result without its end-of-step flags.
  typedef struct packed {
    kind_t               kind;
    logic [OUT_BITS-1:0] row;
    logic [OUT_BITS-1:0] col_start;
    logic [OUT_BITS-1:0] col_end;
  } slot_t;

  // All results of one step: fixed slots, a mask of those present, end flag.
  typedef struct packed {
    slot_t [SLOTS-1:0] slot;
    logic  [SLOTS-1:0] mask;
    logic              done;
  } step_set_t;

endpackage

[rtl/core/mcr_walk.sv]
// ----------------------------------------------------------------------------
// mcr_walk
// Circle state, octant walk update and generation of one step's result set.
// ----------------------------------------------------------------------------
module mcr_walk (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mcr_pkg::in_item_t                  item,
  input  logic                               take,
  input  logic [mcr_pkg::SCREEN_BITS-1:0]    screen_width,
  input  logic [mcr_pkg::SCREEN_BITS-1:0]    screen_height,
  output mcr_pkg::step_set_t                 set
);

  localparam int CB = mcr_pkg::COORD_BITS;
  localparam int XB = mcr_pkg::WALK_X_BITS;
  localparam int CW = mcr_pkg::CALC_BITS;
  localparam int DB = mcr_pkg::DEC_BITS;
  localparam int OB = mcr_pkg::OUT_BITS;
  localparam int SB = mcr_pkg::SCREEN_BITS;
  localparam int NS = mcr_pkg::SLOTS;

  // Circle state.
  logic [CB-1:0] cen_x_r;
  logic [CB-1:0] cen_y_r;
  logic [XB-1:0] walk_x_r;
  logic [CB-1:0] walk_y_r;
  logic [DB-1:0] dec_r;
  logic          fill_r;
  logic          active_r;

  logic signed [CW-1:0] cx, cy, wx, wy;
  logic signed [CW-1:0] cols [NS];
  logic signed [CW-1:0] rows [NS];
  logic        [NS-1:0] vis;
  logic        [CW-1:0] sw_ext, sh_ext;
  logic signed [CW-1:0] d_ext, d_nxt, x_nxt, y_nxt, r_ext, d_start;
  logic                 step_done;

  // Negative values clamp to zero, others keep their low bits.
  function automatic logic [OB-1:0] clamp0(input logic signed [CW-1:0] v);
    clamp0 = v[CW-1] ? '0 : v[OB-1:0];
  endfunction

  // Coordinates of the eight symmetric points and their visibility.
  always_comb begin
    cx = $signed({{(CW-CB){1'b0}}, cen_x_r});
    cy = $signed({{(CW-CB){1'b0}}, cen_y_r});
    wx = $signed({{(CW-XB){1'b0}}, walk_x_r});
    wy = $signed({{(CW-CB){1'b0}}, walk_y_r});
    sw_ext = {{(CW-SB){1'b0}}, screen_width};
    sh_ext = {{(CW-SB){1'b0}}, screen_height};
    cols[0] = cx - wx; rows[0] = cy - wy;
    cols[1] = cx + wx; rows[1] = cy - wy;
    cols[2] = cx - wx; rows[2] = cy + wy;
    cols[3] = cx + wx; rows[3] = cy + wy;
    cols[4] = cx - wy; rows[4] = cy - wx;
    cols[5] = cx + wy; rows[5] = cy - wx;
    cols[6] = cx - wy; rows[6] = cy + wx;
    cols[7] = cx + wy; rows[7] = cy + wx;
    for (int i = 0; i < NS; i++) begin
      vis[i] = !cols[i][CW-1] && !rows[i][CW-1] &&
               ($unsigned(cols[i]) < sw_ext) && ($unsigned(rows[i]) < sh_ext);
    end
  end

  // Decision term update, walk advance and end-of-circle test.
  always_comb begin
    d_ext = $signed({{(CW-DB){dec_r[DB-1]}}, dec_r});
    x_nxt = wx + CW'(1);
    if (d_ext[CW-1]) begin
      d_nxt = d_ext + (wx <<< 2) + CW'(6);
      y_nxt = wy;
    end else begin
      d_nxt = d_ext + ((wx - wy) <<< 2) + CW'(10);
      y_nxt = wy - CW'(1);
    end
    step_done = (x_nxt > y_nxt);
    r_ext     = $signed({{(CW-CB){1'b0}}, item.radius});
    d_start   = CW'(3) - (r_ext <<< 1);
  end

  // Result set of a step taken now.
  always_comb begin
    set = '0;
    if (!active_r) begin
      set.slot[0].kind = mcr_pkg::KIND_IDLE;
      set.mask         = NS'(1);
    end else if (fill_r) begin
      set.slot[0] = '{mcr_pkg::KIND_SPAN, clamp0(cy - wy), clamp0(cx - wx), cols[1][OB-1:0]};
      set.slot[1] = '{mcr_pkg::KIND_SPAN, rows[2][OB-1:0], clamp0(cx - wx), cols[1][OB-1:0]};
      set.slot[2] = '{mcr_pkg::KIND_SPAN, rows[6][OB-1:0], clamp0(cx - wy), cols[5][OB-1:0]};
      set.slot[3] = '{mcr_pkg::KIND_SPAN, clamp0(cy - wx), clamp0(cx - wy), cols[5][OB-1:0]};
      set.mask    = NS'(4'hF);
      set.done    = step_done;
    end else begin
      for (int i = 0; i < NS; i++) begin
        set.slot[i] = '{mcr_pkg::KIND_PIXEL, rows[i][OB-1:0], cols[i][OB-1:0],
                        cols[i][OB-1:0]};
      end
      set.mask = vis;
      if (vis == '0) begin
        set.slot[0] = '{mcr_pkg::KIND_EMPTY, '0, '0, '0};
        set.mask    = NS'(1);
      end
      set.done = step_done;
    end
  end

  // State registers: a start loads the circle, a step advances the walk.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cen_x_r  <= '0;
      cen_y_r  <= '0;
      walk_x_r <= '0;
      walk_y_r <= '0;
      dec_r    <= '0;
      fill_r   <= 1'b0;
      active_r <= 1'b0;
    end else if (take) begin
      if (item.mode == mcr_pkg::MODE_START) begin
        cen_x_r  <= item.center_x;
        cen_y_r  <= item.center_y;
        walk_x_r <= '0;
        walk_y_r <= item.radius;
        dec_r    <= d_start[DB-1:0];
        fill_r   <= item.fill;
        active_r <= 1'b1;
      end else if (active_r) begin
        dec_r    <= d_nxt[DB-1:0];
        walk_x_r <= x_nxt[XB-1:0];
        walk_y_r <= y_nxt[CB-1:0];
        active_r <= !step_done;
      end
    end
  end

endmodule

[rtl/core/mcr_emit.sv]
// ----------------------------------------------------------------------------
// mcr_emit
// Result buffer that holds one step's results and sends them one per cycle while the output does not stall.
// ----------------------------------------------------------------------------
module mcr_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  mcr_pkg::step_set_t  set,
  input  logic                load,
  output logic                free,
  output logic                out_valid,
  input  logic                out_stall,
  output mcr_pkg::out_item_t  out_data
);

  localparam int NS = mcr_pkg::SLOTS;
  localparam int IB = mcr_pkg::SLOT_IDX_BITS;

  mcr_pkg::slot_t [NS-1:0] slot_r;
  logic [NS-1:0]           mask_r;
  logic [NS-1:0]           mask_nxt;
  logic                    done_r;
  logic [IB-1:0]           sel;
  logic [NS-1:0]           rest;
  logic                    last;
  logic                    xfer;

  // Lowest pending slot goes out first.
  always_comb begin
    sel = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = IB'(i);
      end
    end
  end

  assign rest      = mask_r & (mask_r - NS'(1));
  assign last      = (rest == '0);
  assign out_valid = (mask_r != '0);
  assign xfer      = out_valid && !out_stall;
  assign free      = !out_valid || (xfer && last);

  // Output payload from the selected slot.
  always_comb begin
    out_data.kind         = slot_r[sel].kind;
    out_data.row          = slot_r[sel].row;
    out_data.col_start    = slot_r[sel].col_start;
    out_data.col_end      = slot_r[sel].col_end;
    out_data.last_of_step = last;
    out_data.circle_done  = last && done_r;
  end

  // Pending mask: reload on a new step, else drop each transferred slot.
  always_comb begin
    mask_nxt = mask_r;
    if (load) begin
      mask_nxt = set.mask;
    end else if (xfer) begin
      mask_nxt = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  // Slot payloads need no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= set.slot;
      done_r <= set.done;
    end
  end

endmodule

[rtl/core/midpoint_circle_rasterizer.sv]
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// Midpoint circle walk producing clipped outline pixels or filled spans.
// ----------------------------------------------------------------------------
// A start item loads a circle and produces no result; each step item runs one
// iteration of the octant walk and produces up to eight outline pixels (those
// on screen, duplicates kept) or four horizontal spans, or a single status
// result. Results leave one per cycle from the result buffer while the output
// channel does not stall, and this buffer sets the sustained rate. An input
// register in front of the buffer lets the next item be taken while results
// still drain, and start items pass through without waiting for the buffer.
// Screen size registers may be written only while the block is idle.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input item channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  mcr_pkg::in_item_t                    in_data,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output mcr_pkg::out_item_t                   out_data,
  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mcr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [mcr_pkg::SCREEN_BITS-1:0]      cfg_data
);

  logic [mcr_pkg::SCREEN_BITS-1:0] screen_width_r;
  logic [mcr_pkg::SCREEN_BITS-1:0] screen_height_r;
  logic                            in_v_r;
  mcr_pkg::in_item_t               in_item_r;
  logic                            in_xfer;
  logic                            take;
  logic                            load;
  logic                            free;
  mcr_pkg::step_set_t              set;

  // Configuration registers accept a write in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= mcr_pkg::SCREEN_WIDTH_RESET;
      screen_height_r <= mcr_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mcr_pkg::REG_SCREEN_WIDTH:  screen_width_r  <= cfg_data;
        mcr_pkg::REG_SCREEN_HEIGHT: screen_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A held start item is always taken; a step waits for a free buffer.
  assign take     = in_v_r && ((in_item_r.mode == mcr_pkg::MODE_START) || free);
  assign load     = take && (in_item_r.mode == mcr_pkg::MODE_STEP);
  assign in_stall = in_v_r && !take;
  assign in_xfer  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_xfer) begin
      in_v_r <= 1'b1;
    end else if (take) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r <= in_data;
    end
  end

  mcr_walk u_walk (
    .clk           (clk),
    .rst_n         (rst_n),
    .item          (in_item_r),
    .take          (take),
    .screen_width  (screen_width_r),
    .screen_height (screen_height_r),
    .set           (set)
  );

  mcr_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .set       (set),
    .load      (load),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[dv/tb_midpoint_circle_rasterizer.sv]
// ----------------------------------------------------------------------------
// tb_midpoint_circle_rasterizer
// Self-checking testbench for the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
// Circles are started and walked step by step. A behavioral copy of the octant
// walk predicts every pixel, span and status result, and each result transfer
// is compared field by field against the oldest prediction. Directed circles
// cover idle steps, zero radius, edge clipping, span clamping and the largest
// coordinates. Random circles then run under several screen sizes, including
// zero and the widest values, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_midpoint_circle_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  localparam int CB = mcr_pkg::COORD_BITS;
  localparam int XB = mcr_pkg::WALK_X_BITS;
  localparam int DB = mcr_pkg::DEC_BITS;
  localparam int OB = mcr_pkg::OUT_BITS;
  localparam int SB = mcr_pkg::SCREEN_BITS;
  localparam int IB = mcr_pkg::CFG_IDX_BITS;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid  = 1'b0;
  logic               in_stall;
  mcr_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  mcr_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [IB-1:0]      cfg_index = '0;
  logic [SB-1:0]      cfg_data  = '0;

  // Behavioral copy of the walk state and the screen size registers.
  logic [CB-1:0] circ_cx     = '0;
  logic [CB-1:0] circ_cy     = '0;
  logic [XB-1:0] walk_col    = '0;
  logic [CB-1:0] walk_row    = '0;
  logic [DB-1:0] decision    = '0;
  logic          fill_mode   = 1'b0;
  logic          circ_active = 1'b0;
  logic [SB-1:0] scr_width   = mcr_pkg::SCREEN_WIDTH_RESET;
  logic [SB-1:0] scr_height  = mcr_pkg::SCREEN_HEIGHT_RESET;

  // Pixels, spans and status results still to come out of the block, oldest first.
  mcr_pkg::out_item_t raster_queue [$];
  mcr_pkg::out_item_t want_mark;

  int mismatch_count = 0;
  int items_sent     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  midpoint_circle_rasterizer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Free-running clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int clamp_zero(input int v);
    return (v < 0) ? 0 : v;
  endfunction

  function automatic mcr_pkg::out_item_t make_mark(input mcr_pkg::kind_t mark_kind,
                                                   input int row, input int col_lo,
                                                   input int col_hi);
    mcr_pkg::out_item_t m;
    m.kind         = mark_kind;
    m.row          = OB'(row);
    m.col_start    = OB'(col_lo);
    m.col_end      = OB'(col_hi);
    m.last_of_step = 1'b0;
    m.circle_done  = 1'b0;
    return m;
  endfunction

  function automatic string mark_text(input mcr_pkg::out_item_t m);
    return $sformatf("kind=%0d row=%0d cols=%0d..%0d last=%0b done=%0b", m.kind, m.row,
                     m.col_start, m.col_end, m.last_of_step, m.circle_done);
  endfunction

  // Runs one item through the walk and queues the results it produces.
  function automatic void rasterize_item(input mcr_pkg::in_item_t item);
    int cx, cy, x, y, d, n;
    int cols [8];
    int rows [8];
    mcr_pkg::out_item_t marks [8];

    // A start loads the circle and produces nothing.
    if (item.mode == mcr_pkg::MODE_START) begin
      circ_cx     = item.center_x;
      circ_cy     = item.center_y;
      walk_col    = '0;
      walk_row    = item.radius;
      decision    = DB'(3 - 2 * int'(item.radius));
      fill_mode   = item.fill;
      circ_active = 1'b1;
      return;
    end

    // A step with no circle in progress answers with a single status result.
    if (!circ_active) begin
      marks[0] = make_mark(mcr_pkg::KIND_IDLE, 0, 0, 0);
      marks[0].last_of_step = 1'b1;
      raster_queue.push_back(marks[0]);
      return;
    end

    cx = int'(circ_cx);
    cy = int'(circ_cy);
    x  = int'(walk_col);
    y  = int'(walk_row);
    n  = 0;

    if (fill_mode) begin
      // Four spans, clamped at the top and left only.
      marks[0] = make_mark(mcr_pkg::KIND_SPAN, clamp_zero(cy - y), clamp_zero(cx - x),
                           cx + x);
      marks[1] = make_mark(mcr_pkg::KIND_SPAN, cy + y, clamp_zero(cx - x), cx + x);
      marks[2] = make_mark(mcr_pkg::KIND_SPAN, cy + x, clamp_zero(cx - y), cx + y);
      marks[3] = make_mark(mcr_pkg::KIND_SPAN, clamp_zero(cy - x), clamp_zero(cx - y),
                           cx + y);
      n = 4;
    end else begin
      // Eight symmetric pixels, each clipped against all four sides of the screen.
      cols[0] = cx - x; rows[0] = cy - y;
      cols[1] = cx + x; rows[1] = cy - y;
      cols[2] = cx - x; rows[2] = cy + y;
      cols[3] = cx + x; rows[3] = cy + y;
      cols[4] = cx - y; rows[4] = cy - x;
      cols[5] = cx + y; rows[5] = cy - x;
      cols[6] = cx - y; rows[6] = cy + x;
      cols[7] = cx + y; rows[7] = cy + x;
      for (int i = 0; i < 8; i++) begin
        if (cols[i] >= 0 && rows[i] >= 0 &&
            cols[i] < int'(scr_width) && rows[i] < int'(scr_height)) begin
          marks[n] = make_mark(mcr_pkg::KIND_PIXEL, rows[i], cols[i], cols[i]);
          n++;
        end
      end
      if (n == 0) begin
        marks[0] = make_mark(mcr_pkg::KIND_EMPTY, 0, 0, 0);
        n = 1;
      end
    end

    // Decision update on the 16-bit wrapping term.
    d = int'($signed(decision));
    if (d < 0) begin
      d += 4 * x + 6;
    end else begin
      d += 4 * (x - y) + 10;
      y--;
    end
    x++;
    decision = DB'(d);
    walk_col = XB'(x);
    walk_row = CB'(y);

    marks[n-1].last_of_step = 1'b1;
    marks[n-1].circle_done  = (x > y);
    if (x > y) begin
      circ_active = 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      raster_queue.push_back(marks[i]);
    end
  endfunction

  function automatic mcr_pkg::in_item_t start_item(input int cx, input int cy, input int r,
                                                   input logic fill_on);
    mcr_pkg::in_item_t item;
    item.mode     = mcr_pkg::MODE_START;
    item.center_x = CB'(cx);
    item.center_y = CB'(cy);
    item.radius   = CB'(r);
    item.fill     = fill_on;
    return item;
  endfunction

  // A step item; the remaining fields are ignored by the block, so they carry noise.
  function automatic mcr_pkg::in_item_t step_item();
    mcr_pkg::in_item_t item;
    item.mode     = mcr_pkg::MODE_STEP;
    item.center_x = CB'($urandom());
    item.center_y = CB'($urandom());
    item.radius   = CB'($urandom());
    item.fill     = 1'($urandom());
    return item;
  endfunction

  // Picks a center that is anywhere, on the screen, or close to its edges.
  function automatic mcr_pkg::in_item_t random_start(input int r);
    int span_w, span_h, cx, cy;
    span_w = (scr_width  > 4095) ? 4095 : int'(scr_width);
    span_h = (scr_height > 4095) ? 4095 : int'(scr_height);
    case ($urandom_range(0, 3))
      0: begin
        cx = $urandom_range(0, 4095);
        cy = $urandom_range(0, 4095);
      end
      1, 2: begin
        cx = $urandom_range(0, span_w);
        cy = $urandom_range(0, span_h);
      end
      default: begin
        cx = $urandom_range(0, 1) ? $urandom_range(0, r) : span_w - $urandom_range(0, r);
        cy = $urandom_range(0, 1) ? $urandom_range(0, r) : span_h - $urandom_range(0, r);
      end
    endcase
    cx = (cx < 0) ? 0 : (cx > 4095) ? 4095 : cx;
    cy = (cy < 0) ? 0 : (cy > 4095) ? 4095 : cy;
    return start_item(cx, cy, r, 1'($urandom()));
  endfunction

  // Presents one item after a random gap and holds it until the transfer.
  task automatic send_item(input mcr_pkg::in_item_t item);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rasterize_item(item);
    items_sent++;
  endtask

  // Steps the current circle until it ends or the step budget runs out.
  task automatic walk_circle(input int max_steps);
    int k;
    k = 0;
    while (circ_active && k < max_steps) begin
      send_item(step_item());
      k++;
    end
  endtask

  // Stops sending, waits for every queued result and lets the block settle.
  task automatic wait_raster_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (raster_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [IB-1:0] index, input logic [SB-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (index == mcr_pkg::REG_SCREEN_WIDTH) begin
      scr_width = value;
    end else begin
      scr_height = value;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_screen_size(input logic [SB-1:0] width,
                                   input logic [SB-1:0] height);
    wait_raster_drained();
    cfg_write(mcr_pkg::REG_SCREEN_WIDTH, width);
    cfg_write(mcr_pkg::REG_SCREEN_HEIGHT, height);
  endtask

  // Steps with no circle loaded, before any circle has started.
  task automatic test_idle_steps();
    send_item(step_item());
    send_item(step_item());
  endtask

  // Zero radius: eight coincident pixels or four one-pixel spans in one step.
  task automatic test_degenerate_radius();
    send_item(start_item(100, 150, 0, 1'b0));
    walk_circle(4);
    send_item(step_item());
    send_item(start_item(0, 0, 0, 1'b1));
    walk_circle(4);
  endtask

  // Clipping at the top, left, bottom and right edges, and span clamping.
  task automatic test_edge_clipping();
    send_item(start_item(0, 0, 3, 1'b0));
    walk_circle(8);
    send_item(start_item(239, 319, 2, 1'b0));
    walk_circle(8);
    send_item(start_item(2, 1, 4, 1'b1));
    walk_circle(2);
  endtask

  // Largest centers and radii: clipped outlines, one of them fully clipped, and wide spans.
  task automatic test_extreme_circles();
    send_item(start_item(4095, 4095, 4095, 1'b0));
    walk_circle(1);
    send_item(start_item(4095, 4095, 4095, 1'b1));
    walk_circle(2);
    send_item(start_item(0, 0, 4095, 1'b1));
    walk_circle(1);
    send_item(start_item(4095, 0, 4095, 1'b0));
    walk_circle(1);
  endtask

  // Random circles under one screen size and one idling mix.
  task automatic test_random_circles(input int n_items,
                                     input logic [SB-1:0] width,
                                     input logic [SB-1:0] height,
                                     input int send_pct, input int stall_pct);
    int stop_at, r;
    write_screen_size(width, height);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 4) == 0) begin
        // Broken walk: any radius, abandoned after a few steps.
        r = $urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 12);
        send_item(random_start(r));
        walk_circle($urandom_range(0, 3));
      end else begin
        // Complete walk of a small circle.
        r = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        send_item(random_start(r));
        walk_circle(64);
      end
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) send_item(step_item());
      end
      // Now and then the sender holds off until the block has emptied.
      if ($urandom_range(0, 24) == 0) begin
        wait_raster_drained();
      end
    end
  endtask

  // The receiver stalls at random on the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Each result transfer is compared with the oldest queued prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (raster_queue.size() == 0) begin
        if (mismatch_count < MAX_REPORTS) begin
          $display("Unexpected result with nothing pending: %s", mark_text(out_data));
        end
        mismatch_count++;
      end else begin
        want_mark = raster_queue.pop_front();
        if (out_data.kind !== want_mark.kind || out_data.row !== want_mark.row ||
            out_data.col_start !== want_mark.col_start ||
            out_data.col_end !== want_mark.col_end ||
            out_data.last_of_step !== want_mark.last_of_step ||
            out_data.circle_done !== want_mark.circle_done) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("Result mismatch: expected %s, got %s", mark_text(want_mark),
                     mark_text(out_data));
          end
          mismatch_count++;
        end
      end
    end
  end

  // Ends the run when no transfer of any kind happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Test sequence.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_steps();
    test_degenerate_radius();
    test_edge_clipping();
    test_extreme_circles();

    test_random_circles(45, mcr_pkg::SCREEN_WIDTH_RESET, mcr_pkg::SCREEN_HEIGHT_RESET,
                        0, 0);
    test_random_circles(40, 14'd8192, 14'd8192, 53, 0);
    test_random_circles(40, SB'($urandom_range(1, 64)), SB'($urandom_range(1, 96)),
                        0, 53);
    test_random_circles(30, 14'd16383, 14'd1, 17, 17);
    test_random_circles(20, 14'd0, 14'd0, 17, 17);

    wait_raster_drained();
    if (mismatch_count == 0 && raster_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
